// ----- sv/cannon_block_matrix_multiply_unit_macros.svh -----
// Assertion macros shared by the Cannon matrix multiply unit.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CANNON_BLOCK_MATRIX_MULTIPLY_UNIT_MACROS_SVH
`define CANNON_BLOCK_MATRIX_MULTIPLY_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CBMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked out of reset
`define CBMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ----- sv/cbmm_pkg.sv -----
// Shared types and constants of the Cannon matrix multiply unit.
// Used by the controller, the datapath and the top level.
package cbmm_pkg;

    // Element stores are 8 x 8, indexed {row, col}
    localparam int IDX_W  = 3;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 40;

    // Request codes
    localparam logic [1:0] REQ_LOAD_A   = 2'd0;
    localparam logic [1:0] REQ_LOAD_B   = 2'd1;
    localparam logic [1:0] REQ_LOAD_ACC = 2'd2;
    localparam logic [1:0] REQ_COMPUTE  = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic                     wr_a;
        logic                     wr_b;
        logic                     wr_acc;
        logic [ADDR_W-1:0]        wr_addr;
        logic signed [ELEM_W-1:0] wr_value;
        logic                     issue;
        logic                     first;
        logic [ADDR_W-1:0]        a_addr;
        logic [ADDR_W-1:0]        b_addr;
        logic [ADDR_W-1:0]        acc_addr;
        logic                     clear_acc;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic busy;
    } t_sts;

endpackage

// ----- sv/cbmm_dp.sv -----
// Datapath: A, B and accumulator stores, multiply pipeline and saturating accumulator.
// Depends on cbmm_pkg; driven by cbmm_ctrl through t_cmd.
module cbmm_dp
    import cbmm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    output logic signed [ACC_W-1:0] o_acc,
    output logic                    o_sat
);

    localparam int DEPTH = 1 << ADDR_W;

    logic signed [ELEM_W-1:0] a_mem [DEPTH];
    logic signed [ELEM_W-1:0] b_mem [DEPTH];
    logic signed [ACC_W-1:0]  acc_mem [DEPTH];
    logic [DEPTH-1:0]         r_acc_vld;

    logic signed [ELEM_W-1:0] r_a_q;
    logic signed [ELEM_W-1:0] r_b_q;
    logic signed [ACC_W-1:0]  r_acc_q;
    logic                     r_p1_vld;
    logic                     r_p1_first;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_p2_vld;
    logic                     r_p2_first;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_sat;

    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W:0]    sum;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     ovf;

    // A store: write on load, read registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            a_mem[i_cmd.wr_addr] <= i_cmd.wr_value;
        end
        r_a_q <= a_mem[i_cmd.a_addr];
    end

    // B store: write on load, read registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) begin
            b_mem[i_cmd.wr_addr] <= i_cmd.wr_value;
        end
        r_b_q <= b_mem[i_cmd.b_addr];
    end

    // Accumulator store: value scaled to Q32.8, read at the first product of an element
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_acc) begin
            acc_mem[i_cmd.wr_addr] <= {{(ACC_W-ELEM_W-8){i_cmd.wr_value[ELEM_W-1]}},
                                       i_cmd.wr_value, 8'b0};
        end
        if (i_cmd.issue && i_cmd.first) begin
            r_acc_q <= r_acc_vld[i_cmd.acc_addr] ? acc_mem[i_cmd.acc_addr] : '0;
        end
    end

    // Valid bits: an entry not valid reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_acc) begin
            r_acc_vld <= '0;
        end else if (i_cmd.wr_acc) begin
            r_acc_vld[i_cmd.wr_addr] <= 1'b1;
        end
    end

    // Pipeline control: read stage, then multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_cmd.issue;
            r_p2_vld <= r_p1_vld;
        end
    end

    // Multiply the registered operands
    always_ff @(posedge i_clk) begin
        r_p1_first <= i_cmd.first;
        r_p2_first <= r_p1_first;
        r_prod     <= r_a_q * r_b_q;
    end

    // Saturating add of the product
    always_comb begin
        base  = r_p2_first ? r_acc_q : r_acc;
        sum   = {base[ACC_W-1], base} + {{(ACC_W+1-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        ovf   = sum[ACC_W] != sum[ACC_W-1];
        n_acc = sum[ACC_W-1:0];
        if (ovf) begin
            n_acc = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    // Accumulate; the saturation flag is sticky within an element
    always_ff @(posedge i_clk) begin
        if (r_p2_vld) begin
            r_acc <= n_acc;
            r_sat <= ovf || (!r_p2_first && r_sat);
        end
    end

    assign o_sts.busy = r_p1_vld || r_p2_vld;
    assign o_acc      = r_acc;
    assign o_sat      = r_sat;

endmodule

// ----- sv/cbmm_ctrl.sv -----
// Controller: input handshake, Cannon step sequencing and result transfer.
// Depends on cbmm_pkg and the assertion macros; drives cbmm_dp through t_cmd.
`include "cannon_block_matrix_multiply_unit_macros.svh"
module cbmm_ctrl
    import cbmm_pkg::*;
#(
    parameter int BLOCK_EDGE      = 4,
    parameter int BLOCKS_PER_SIDE = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_req_type,
    input  logic [IDX_W-1:0]         i_row,
    input  logic [IDX_W-1:0]         i_col,
    input  logic signed [ELEM_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic                     o_last,
    output t_cmd                     o_cmd,
    input  t_sts                     i_sts
);

    localparam int DIM_RAW = BLOCK_EDGE * BLOCKS_PER_SIDE;
    localparam int DIM     = (DIM_RAW > (1 << IDX_W)) ? (1 << IDX_W) : DIM_RAW;
    localparam logic [IDX_W-1:0] DIM_M1 = IDX_W'(DIM - 1);
    localparam logic [IDX_W-1:0] BE_M1  = IDX_W'(BLOCK_EDGE - 1);
    localparam logic [IDX_W-1:0] BC_M1  = IDX_W'(BLOCKS_PER_SIDE - 1);
    localparam logic [IDX_W+1:0] BC_EXT = (IDX_W+2)'(BLOCKS_PER_SIDE);
    localparam logic [2*IDX_W-1:0] BE_EXT = (2*IDX_W)'(BLOCK_EDGE);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_row, n_row, r_col, n_col;
    logic [IDX_W-1:0] r_bi, n_bi, r_bj, n_bj;
    logic [IDX_W-1:0] r_ri, n_ri, r_ci, n_ci;
    logic [IDX_W-1:0] r_s, n_s, r_k, n_k;

    logic             in_xfer;
    logic             out_xfer;
    logic             last_elem;
    logic [IDX_W+1:0] blk_sum, blk_red1, blk_red2;
    logic [IDX_W-1:0] blk;
    logic [2*IDX_W-1:0] m_full;
    logic [IDX_W-1:0] m_idx;

    assign in_xfer   = i_valid && !o_stall;
    assign out_xfer  = o_valid && !i_stall;
    assign last_elem = (r_row == DIM_M1) && (r_col == DIM_M1);

    // Block index of this step: (bi + bj + s) mod BLOCKS_PER_SIDE, all terms below it
    always_comb begin
        blk_sum  = (IDX_W+2)'(r_bi) + (IDX_W+2)'(r_bj) + (IDX_W+2)'(r_s);
        blk_red1 = (blk_sum >= BC_EXT) ? blk_sum - BC_EXT : blk_sum;
        blk_red2 = (blk_red1 >= BC_EXT) ? blk_red1 - BC_EXT : blk_red1;
        blk      = blk_red2[IDX_W-1:0];
        m_full   = (2*IDX_W)'(blk) * BE_EXT + (2*IDX_W)'(r_k);
        m_idx    = m_full[IDX_W-1:0];
    end

    // Next state and counters
    always_comb begin
        n_state = r_state;
        n_row = r_row; n_col = r_col;
        n_bi  = r_bi;  n_bj  = r_bj;
        n_ri  = r_ri;  n_ci  = r_ci;
        n_s   = r_s;   n_k   = r_k;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_req_type == REQ_COMPUTE) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_k == BE_M1) begin
                    n_k = '0;
                    if (r_s == BC_M1) begin
                        n_s     = '0;
                        n_state = ST_DRAIN;
                    end else begin
                        n_s = r_s + 1'b1;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_xfer) begin
                    if (r_col == DIM_M1) begin
                        n_col = '0; n_ci = '0; n_bj = '0;
                        if (r_row == DIM_M1) begin
                            n_row = '0; n_ri = '0; n_bi = '0;
                        end else begin
                            n_row = r_row + 1'b1;
                            if (r_ri == BE_M1) begin
                                n_ri = '0;
                                n_bi = r_bi + 1'b1;
                            end else begin
                                n_ri = r_ri + 1'b1;
                            end
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                        if (r_ci == BE_M1) begin
                            n_ci = '0;
                            n_bj = r_bj + 1'b1;
                        end else begin
                            n_ci = r_ci + 1'b1;
                        end
                    end
                    n_state = last_elem ? ST_IDLE : ST_MAC;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row <= '0; r_col <= '0;
            r_bi  <= '0; r_bj  <= '0;
            r_ri  <= '0; r_ci  <= '0;
            r_s   <= '0; r_k   <= '0;
        end else begin
            r_state <= n_state;
            r_row <= n_row; r_col <= n_col;
            r_bi  <= n_bi;  r_bj  <= n_bj;
            r_ri  <= n_ri;  r_ci  <= n_ci;
            r_s   <= n_s;   r_k   <= n_k;
        end
    end

    // Commands to the datapath
    always_comb begin
        o_cmd           = '0;
        o_cmd.wr_addr   = {i_row, i_col};
        o_cmd.wr_value  = i_value;
        o_cmd.wr_a      = in_xfer && i_req_type == REQ_LOAD_A;
        o_cmd.wr_b      = in_xfer && i_req_type == REQ_LOAD_B;
        o_cmd.wr_acc    = in_xfer && i_req_type == REQ_LOAD_ACC;
        o_cmd.issue     = r_state == ST_MAC;
        o_cmd.first     = (r_s == '0) && (r_k == '0);
        o_cmd.a_addr    = {r_row, m_idx};
        o_cmd.b_addr    = {m_idx, r_col};
        o_cmd.acc_addr  = {r_row, r_col};
        o_cmd.clear_acc = out_xfer && last_elem;
    end

    assign o_stall   = r_state != ST_IDLE;
    assign o_valid   = r_state == ST_EMIT;
    assign o_out_row = r_row;
    assign o_out_col = r_col;
    assign o_last    = last_elem;

    `CBMM_ASSERT_IMP(a_emit_drained, i_clk, i_rst_n, o_valid, !i_sts.busy && o_stall)
    `CBMM_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, out_xfer && last_elem,
                     r_state == ST_IDLE && !o_stall)
    `CBMM_ASSERT_NXT(a_more_to_mac, i_clk, i_rst_n, out_xfer && !last_elem,
                     r_state == ST_MAC && o_cmd.first)
    `CBMM_ASSERT_IMP(a_no_load_in_run, i_clk, i_rst_n, o_cmd.issue,
                     !o_cmd.wr_a && !o_cmd.wr_b && !o_cmd.wr_acc)

endmodule

// ----- sv/cannon_block_matrix_multiply_unit.sv -----
// Cannon block matrix multiply unit: the top level.
// Depends on cbmm_pkg, cbmm_ctrl and cbmm_dp.
//
// Input channel (i_valid / o_stall): each transfer carries a request. Load A,
// load B and load accumulator write one element at (row, col); while o_stall
// is low, loads stream at one per cycle and produce no result. A compute request
// forms C = acc + A*B over the BLOCK_EDGE*BLOCKS_PER_SIDE matrix (edge capped
// at 8) in Cannon order and raises o_stall until its last result is taken.
// Output channel (o_valid / i_stall): results come in row order, one per
// element, with o_last on the final one. For each element, products issue
// one per cycle through the single shared multiplier into the read,
// multiply and accumulate pipeline, and the result is presented once the
// pipeline has drained. A stall holds the result and pauses the sequence.
// After the last result the accumulator store reads as zero again.
// Reset clears the controller and the accumulator store; the A and B stores
// hold nothing defined until written.
module cannon_block_matrix_multiply_unit
    import cbmm_pkg::*;
#(
    parameter int BLOCK_EDGE      = 4,
    parameter int BLOCKS_PER_SIDE = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_req_type,
    input  logic [IDX_W-1:0]         i_row,
    input  logic [IDX_W-1:0]         i_col,
    input  logic signed [ELEM_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [IDX_W-1:0]         o_out_row,
    output logic [IDX_W-1:0]         o_out_col,
    output logic signed [ACC_W-1:0]  o_out_value,
    output logic                     o_saturated,
    output logic                     o_last
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer and handshakes
    cbmm_ctrl #(
        .BLOCK_EDGE      (BLOCK_EDGE),
        .BLOCKS_PER_SIDE (BLOCKS_PER_SIDE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_row  (o_out_row),
        .o_out_col  (o_out_col),
        .o_last     (o_last),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // Stores and arithmetic
    cbmm_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_acc   (o_out_value),
        .o_sat   (o_saturated)
    );

endmodule
